@@ design/lsp_pkg.sv @@
package lsp_pkg;

    // Field and register widths
    localparam int SAMPLE_W       = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam int ADDR_W         = 16;
    localparam int FRAME_COUNT_W  = 17;
    localparam int SKIP_W         = 24;
    localparam int SKIP_FRAC      = 8;
    localparam int SKIP_INT_W     = SKIP_W - SKIP_FRAC;
    localparam int GAIN_W         = 16;
    localparam int GAIN_FRAC      = 12;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 24;
    localparam int DIST_W         = SAMPLE_W + 1;

    // Parameter defaults
    localparam int DEF_MAX_FRAMES  = 65536;
    localparam int DEF_SEARCH_SPAN = 400;

    // Constants
    localparam logic [SKIP_W-1:0] SKIP_MAX       = 24'hFFFFFF;
    localparam logic [SKIP_W-1:0] SKIP_RESET     = 24'd256;
    localparam logic [DIST_W-1:0] START_DISTANCE = 17'd32000;

    // Register reset values
    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 17'd65536;
    localparam logic [GAIN_W-1:0]        GAIN_RESET        = 16'd4096;

    // Request modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_PLAY  = 2'd1;
    localparam logic [1:0] MODE_ALIGN = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_FORWARD  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_GAIN   = 2'd3;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [ADDR_W-1:0]          load_address;
        logic signed [SAMPLE_W-1:0] load_left;
        logic signed [SAMPLE_W-1:0] load_right;
        logic signed [SAMPLE_W-1:0] partner_last_value;
        logic                       partner_rising;
    } t_req;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic [ADDR_W-1:0]          play_position;
    } t_rsp;

endpackage

@@ design/looped_sample_player_with_skip_pitch.sv @@
// Looped stereo sample player with pitch change by frame skip or repeat.
//
// Request channel: a request is taken at a rising edge with i_start high
// and o_busy low. i_req.mode selects load (write one frame), play (output
// the next scaled frame), align (search ahead for a match to a partner)
// or no operation. Every request gives exactly one response on o_rsp,
// marked by a one-cycle o_done strobe; the receiver cannot stall it.
// Load and no-op answer in the next cycle and never raise o_busy. Play
// runs three extra steps of the shared skip adder when a skip or repeat
// falls due. Align reads one frame per cycle from the frame store and
// compares at most SEARCH_SPAN frames before it answers. o_busy drops in
// the cycle o_done is shown, so the next request can be taken there.
// Configuration: i_cfg_valid/o_cfg_ready write the register i_cfg_index;
// o_cfg_ready is high while the block is not busy.
// Reset (synchronous, i_rst_n low) sets position 0, skip position 1.0,
// default registers. The frame store is not cleared; frames must be
// loaded before they are played.
module looped_sample_player_with_skip_pitch
    import lsp_pkg::*;
#(
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int SEARCH_SPAN = DEF_SEARCH_SPAN
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  t_req                   i_req,
    output logic                   o_done,
    output t_rsp                   o_rsp,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PW = $clog2(MAX_FRAMES);
    localparam int NW = PW + 1;
    localparam int AW = (PW + SKIP_FRAC + 1 > SKIP_W + 1) ? PW + SKIP_FRAC + 1 : SKIP_W + 1;
    localparam int CW = $clog2(SEARCH_SPAN + 1);
    localparam int FW = 2 * SAMPLE_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PSK1  = 4'd1;
    localparam logic [3:0] S_PSK2  = 4'd2;
    localparam logic [3:0] S_PSK3  = 4'd3;
    localparam logic [3:0] S_PSK4  = 4'd4;
    localparam logic [3:0] S_PREAD = 4'd5;
    localparam logic [3:0] S_PMULL = 4'd6;
    localparam logic [3:0] S_PMULR = 4'd7;
    localparam logic [3:0] S_PFIN  = 4'd8;
    localparam logic [3:0] S_APREV = 4'd9;
    localparam logic [3:0] S_AWALK = 4'd10;

    // Control state
    logic [3:0]               r_state;
    logic [PW-1:0]            r_position;
    logic [SKIP_W-1:0]        r_skip;
    logic signed [SAMPLE_W-1:0] r_last_left;
    logic                     r_last_rising;
    logic                     r_done;
    logic [FRAME_COUNT_W-1:0] r_frame_count;
    logic [SKIP_W-1:0]        r_skip_interval;
    logic                     r_step_forward;
    logic [GAIN_W-1:0]        r_volume_gain;

    // Working registers
    logic [AW-1:0]              r_acc;
    logic [PW-1:0]              r_sh;
    logic [SKIP_INT_W-1:0]      r_ssk;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic [PW-1:0]              r_best;
    logic [SKIP_INT_W-1:0]      r_best_skip;
    logic [DIST_W-1:0]          r_best_dist;
    logic [CW-1:0]              r_cnt;
    logic signed [SAMPLE_W-1:0] r_pv;
    logic                       r_prising;
    logic signed [SAMPLE_W-1:0] r_left;
    t_rsp                       r_rsp;

    logic w_accept;
    logic w_cfg_accept;

    assign o_busy       = (r_state != S_IDLE);
    assign o_cfg_ready  = !o_busy;
    assign w_accept     = i_start && !o_busy;
    assign w_cfg_accept = i_cfg_valid && o_cfg_ready;
    assign o_done       = r_done;
    assign o_rsp        = r_rsp;

    // Loop length clamped to 1..MAX_FRAMES
    logic [NW-1:0] w_len;
    logic [NW-1:0] w_len_m1;
    always_comb begin
        if (r_frame_count == '0) begin
            w_len = NW'(1);
        end else if (32'(r_frame_count) > 32'(MAX_FRAMES)) begin
            w_len = NW'(MAX_FRAMES);
        end else begin
            w_len = NW'(r_frame_count);
        end
        w_len_m1 = w_len - NW'(1);
    end

    // Wrapping steps of the play position and of the search pointers
    logic [NW-1:0]         w_pos_inc;
    logic [PW-1:0]         w_pos_next;
    logic [PW-1:0]         w_pos_prev;
    logic [NW-1:0]         w_sh_inc;
    logic [PW-1:0]         w_sh_next;
    logic [SKIP_INT_W:0]   w_ssk_inc;
    logic [SKIP_INT_W-1:0] w_ssk_next;
    always_comb begin
        w_pos_inc  = {1'b0, r_position} + NW'(1);
        w_pos_next = (w_pos_inc >= w_len) ? '0 : w_pos_inc[PW-1:0];
        w_pos_prev = (r_position == '0) ? w_len_m1[PW-1:0] : r_position - PW'(1);
        w_sh_inc   = {1'b0, r_sh} + NW'(1);
        w_sh_next  = (w_sh_inc >= w_len) ? '0 : w_sh_inc[PW-1:0];
        w_ssk_inc  = {1'b0, r_ssk} + (SKIP_INT_W + 1)'(1);
        w_ssk_next = (32'(w_ssk_inc) >= 32'(w_len)) ? '0 : w_ssk_inc[SKIP_INT_W-1:0];
    end

    // Skip arithmetic operands, all in 16.8
    logic [AW-1:0] w_pos8;
    logic [AW-1:0] w_end8;
    logic [AW-1:0] w_intv;
    logic          w_skip_due;
    assign w_pos8 = AW'({r_position, 8'h00});
    assign w_end8 = AW'({w_len_m1, 8'h00});
    assign w_intv = AW'(r_skip_interval);
    assign w_skip_due = (r_skip_interval != '0) &&
                        ((32'(r_position) == 32'(r_skip[SKIP_W-1:SKIP_FRAC])) ||
                         (r_skip == '0));

    // Frame store
    logic          w_we;
    logic [PW-1:0] w_waddr;
    logic [FW-1:0] w_wdata;
    logic          w_re;
    logic [PW-1:0] w_raddr;
    logic [FW-1:0] w_rdata;

    assign w_we    = w_accept && (i_req.mode == MODE_LOAD) &&
                     (32'(i_req.load_address) < 32'(MAX_FRAMES));
    assign w_waddr = PW'(i_req.load_address);
    assign w_wdata = {i_req.load_right, i_req.load_left};

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_position;
        case (r_state)
            S_IDLE: begin
                w_re = w_accept && (i_req.mode == MODE_ALIGN);
            end
            S_PREAD: begin
                w_re = 1'b1;
            end
            S_APREV, S_AWALK: begin
                w_re    = 1'b1;
                w_raddr = w_sh_next;
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    lsp_frame_store #(
        .DEPTH (MAX_FRAMES),
        .AW    (PW),
        .DW    (FW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic signed [SAMPLE_W-1:0] w_cur_left;
    logic signed [SAMPLE_W-1:0] w_cur_right;
    assign w_cur_left  = w_rdata[SAMPLE_W-1:0];
    assign w_cur_right = w_rdata[FW-1:SAMPLE_W];

    // Shared gain unit: left sample first, right in the cycle after
    logic signed [SAMPLE_W-1:0] w_scale_in;
    logic signed [SAMPLE_W-1:0] w_scaled;
    assign w_scale_in = (r_state == S_PMULR) ? w_cur_right : w_cur_left;

    lsp_scale u_scale (
        .i_clk    (i_clk),
        .i_sample (w_scale_in),
        .i_gain   (r_volume_gain),
        .o_scaled (w_scaled)
    );

    // Search step: crossing test and closest-frame tracking
    logic signed [DIST_W-1:0]   w_diff;
    logic [DIST_W-1:0]          w_dist;
    logic                       w_stop;
    logic                       w_closer;
    logic [PW-1:0]              n_best;
    logic [SKIP_INT_W-1:0]      n_best_skip;
    logic                       w_last_step;
    always_comb begin
        w_diff = DIST_W'(r_pv) - DIST_W'(w_cur_left);
        w_dist = w_diff[DIST_W-1] ? DIST_W'(-w_diff) : DIST_W'(w_diff);
        if (r_prev < w_cur_left) begin
            w_stop = r_prising && (r_prev < r_pv) && (w_cur_left >= r_pv);
        end else begin
            w_stop = !r_prising && (r_prev > r_pv) && (w_cur_left <= r_pv);
        end
        w_closer    = (w_dist < r_best_dist);
        n_best      = w_closer ? r_sh : r_best;
        n_best_skip = w_closer ? r_ssk : r_best_skip;
        w_last_step = (r_cnt == CW'(SEARCH_SPAN - 1));
    end

    // Sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_position      <= '0;
            r_skip          <= SKIP_RESET;
            r_last_left     <= '0;
            r_last_rising   <= 1'b0;
            r_done          <= 1'b0;
            r_frame_count   <= FRAME_COUNT_RESET;
            r_skip_interval <= '0;
            r_step_forward  <= 1'b0;
            r_volume_gain   <= GAIN_RESET;
        end else begin
            r_done <= 1'b0;

            if (w_cfg_accept) begin
                case (i_cfg_index)
                    CFG_FRAME_COUNT:   r_frame_count   <= i_cfg_data[FRAME_COUNT_W-1:0];
                    CFG_SKIP_INTERVAL: r_skip_interval <= i_cfg_data[SKIP_W-1:0];
                    CFG_STEP_FORWARD:  r_step_forward  <= i_cfg_data[0];
                    CFG_VOLUME_GAIN:   r_volume_gain   <= i_cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_req.mode)
                            MODE_PLAY:  r_state <= S_PSK1;
                            MODE_ALIGN: r_state <= S_APREV;
                            default:    r_done  <= 1'b1;
                        endcase
                    end
                end
                S_PSK1: begin
                    r_state <= w_skip_due ? S_PSK2 : S_PREAD;
                end
                S_PSK2: begin
                    r_state <= S_PSK3;
                end
                S_PSK3: begin
                    r_state <= S_PSK4;
                end
                S_PSK4: begin
                    r_skip     <= (r_acc > AW'(SKIP_MAX)) ? SKIP_MAX : r_acc[SKIP_W-1:0];
                    r_position <= r_step_forward ? w_pos_next : w_pos_prev;
                    r_state    <= S_PREAD;
                end
                S_PREAD: begin
                    r_state <= S_PMULL;
                end
                S_PMULL: begin
                    r_state <= S_PMULR;
                end
                S_PMULR: begin
                    r_state <= S_PFIN;
                end
                S_PFIN: begin
                    r_position    <= w_pos_next;
                    r_last_rising <= (r_last_left < r_left);
                    r_last_left   <= r_left;
                    r_done        <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_APREV: begin
                    r_state <= S_AWALK;
                end
                S_AWALK: begin
                    if (w_stop) begin
                        r_position <= r_sh;
                        r_skip     <= {r_ssk, 8'h00};
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end else if (w_last_step) begin
                        r_position <= n_best;
                        r_skip     <= {n_best_skip, 8'h00};
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Working data path registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pv        <= i_req.partner_last_value;
                r_prising   <= i_req.partner_rising;
                r_sh        <= r_position;
                r_ssk       <= r_skip[SKIP_W-1:SKIP_FRAC];
                r_best      <= r_position;
                r_best_skip <= r_skip[SKIP_W-1:SKIP_FRAC];
                r_best_dist <= START_DISTANCE;
                r_cnt       <= '0;
                r_rsp       <= '{left_out: '0, right_out: '0,
                                 play_position: ADDR_W'(r_position)};
            end
            S_PSK1: begin
                r_acc <= AW'(r_skip) + w_intv;
            end
            S_PSK2: begin
                if (r_acc < w_pos8) begin
                    r_acc <= w_pos8 + w_intv;
                end
            end
            S_PSK3: begin
                if (r_acc > w_end8) begin
                    r_acc <= r_acc - w_end8;
                end
            end
            S_PMULR: begin
                r_left <= w_scaled;
            end
            S_PFIN: begin
                r_rsp <= '{left_out: r_left, right_out: w_scaled,
                           play_position: ADDR_W'(w_pos_next)};
            end
            S_APREV: begin
                r_prev <= w_cur_left;
                r_sh   <= w_sh_next;
                r_ssk  <= w_ssk_next;
            end
            S_AWALK: begin
                r_best      <= n_best;
                r_best_skip <= n_best_skip;
                if (w_closer) begin
                    r_best_dist <= w_dist;
                end
                r_prev <= w_cur_left;
                r_sh   <= w_sh_next;
                r_ssk  <= w_ssk_next;
                r_cnt  <= r_cnt + CW'(1);
                if (w_stop) begin
                    r_rsp <= '{left_out: '0, right_out: '0,
                               play_position: ADDR_W'(r_sh)};
                end else begin
                    r_rsp <= '{left_out: '0, right_out: '0,
                               play_position: ADDR_W'(n_best)};
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // A response strobe always comes with the sequencer back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("response strobe while sequencer busy");

    // Load and no-op requests answer in the next cycle
    a_short_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.mode == MODE_LOAD || i_req.mode == MODE_NOP)) |=> o_done)
        else $error("load or no-op request got no response");

    // Play and align requests hold the block busy
    a_long_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.mode == MODE_PLAY || i_req.mode == MODE_ALIGN))
        |=> (o_busy && !o_done))
        else $error("play or align request did not occupy the sequencer");

    // The search never runs past its span
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AWALK) |-> (32'(r_cnt) < 32'(SEARCH_SPAN)))
        else $error("align search ran past its span");
`endif

endmodule

@@ design/lsp_frame_store.sv @@
module lsp_frame_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/lsp_scale.sv @@
module lsp_scale
    import lsp_pkg::*;
(
    input  logic                       i_clk,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [GAIN_W-1:0]          i_gain,
    output logic signed [SAMPLE_W-1:0] o_scaled
);

    localparam int PW = SAMPLE_W + GAIN_W + 1;
    localparam int QW = PW - GAIN_FRAC;
    localparam logic signed [QW-1:0] SAT_HI = QW'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [QW-1:0] SAT_LO = -SAT_HI - QW'(1);
    localparam logic signed [PW-1:0] ROUND_ADJ = PW'((2 ** GAIN_FRAC) - 1);

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] w_adj;
    logic signed [QW-1:0] w_q;
    logic signed [QW-1:0] w_sat;

    // Product stage: signed sample times unsigned gain
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_sample) * $signed({1'b0, i_gain});
    end

    // Shift toward zero, then clamp to the sample range
    always_comb begin
        w_adj = r_prod[PW-1] ? (r_prod + ROUND_ADJ) : r_prod;
        w_q   = QW'(w_adj >>> GAIN_FRAC);
        if (w_q > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_q < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_q;
        end
    end

    assign o_scaled = SAMPLE_W'(w_sat);

endmodule

@@ sim/lsp_player_checker.sv @@
`timescale 1ns / 1ps

// Watches the request, response and register channels of the sample player,
// keeps its own copy of the player state and compares every response.
module lsp_player_checker
    import lsp_pkg::*;
#(
    parameter int SPAN = DEF_SEARCH_SPAN
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  t_req                   i_req,
    input  logic                   i_done,
    input  t_rsp                   i_rsp,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int FRAMES    = DEF_MAX_FRAMES;
    localparam int MAX_SHOWN = 40;

    // Frame store: left sample in the low half, right in the high half
    logic [31:0]              frames [0:FRAMES-1];
    logic [ADDR_W-1:0]        play_pos;
    logic [SKIP_W-1:0]        skip_pos;
    logic [FRAME_COUNT_W-1:0] frame_count;
    logic [SKIP_W-1:0]        skip_interval;
    logic                     step_forward;
    logic [GAIN_W-1:0]        volume_gain;

    t_rsp player_out_q [$];

    // Loop length actually used, clamped to 1..FRAMES
    function automatic int loop_frames();
        if (frame_count == 0) return 1;
        if (frame_count > FRAMES) return FRAMES;
        return frame_count;
    endfunction

    function automatic int next_frame(input int p, input int n);
        return (p + 1 >= n) ? 0 : p + 1;
    endfunction

    function automatic int left_of(input int idx);
        logic signed [SAMPLE_W-1:0] v;
        v = frames[idx][SAMPLE_W-1:0];
        return v;
    endfunction

    // 4.12 gain, truncation toward zero, then saturation to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] apply_gain(
        input logic signed [SAMPLE_W-1:0] s
    );
        longint prod;
        longint q;
        prod = longint'(s) * longint'(volume_gain);
        q = (prod < 0) ? -((-prod) >>> GAIN_FRAC) : (prod >>> GAIN_FRAC);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    // Applies one request to the player copy and returns its response
    task automatic step_player(input t_req r, output t_rsp o);
        int     n;
        int     p;
        int     sh;
        int     ssk;
        int     best;
        int     best_skip;
        int     best_dist;
        int     prev;
        int     cur;
        int     d;
        int     pv;
        int     i;
        bit     found;
        longint sp;
        longint pos8;
        longint end8;
        o = '0;
        n = loop_frames();
        p = play_pos;
        case (r.mode)
            MODE_LOAD: begin
                frames[r.load_address] = {r.load_right, r.load_left};
            end
            MODE_PLAY: begin
                // skip or repeat one frame when the skip point is reached
                if (skip_interval != 0 && (p == skip_pos[SKIP_W-1:SKIP_FRAC] || skip_pos == 0))
                begin
                    sp   = longint'(skip_pos) + longint'(skip_interval);
                    pos8 = longint'(p) << SKIP_FRAC;
                    end8 = longint'(n - 1) << SKIP_FRAC;
                    if (sp < pos8) sp = pos8 + longint'(skip_interval);
                    if (sp > end8) sp = sp - end8;
                    if (sp > longint'(SKIP_MAX)) sp = longint'(SKIP_MAX);
                    skip_pos = sp[SKIP_W-1:0];
                    if (step_forward) p = next_frame(p, n);
                    else p = (p == 0) ? n - 1 : p - 1;
                end
                o.left_out  = apply_gain(frames[p][SAMPLE_W-1:0]);
                o.right_out = apply_gain(frames[p][2*SAMPLE_W-1:SAMPLE_W]);
                p = next_frame(p, n);
            end
            MODE_ALIGN: begin
                pv        = r.partner_last_value;
                sh        = p;
                ssk       = skip_pos[SKIP_W-1:SKIP_FRAC];
                best      = p;
                best_skip = ssk;
                best_dist = START_DISTANCE;
                prev      = left_of(sh);
                found     = 1'b0;
                // first crossing in the partner's direction wins, else closest value
                for (i = 0; i < SPAN && !found; i++) begin
                    sh  = next_frame(sh, n);
                    ssk = next_frame(ssk, n);
                    cur = left_of(sh);
                    if (prev < cur) found = r.partner_rising && prev < pv && cur >= pv;
                    else found = !r.partner_rising && prev > pv && cur <= pv;
                    if (!found) begin
                        d = (pv > cur) ? pv - cur : cur - pv;
                        if (d < best_dist) begin
                            best_dist = d;
                            best      = sh;
                            best_skip = ssk;
                        end
                        prev = cur;
                    end
                end
                if (!found) begin
                    sh  = best;
                    ssk = best_skip;
                end
                p        = sh;
                skip_pos = SKIP_W'(ssk) << SKIP_FRAC;
            end
            default: begin
            end
        endcase
        play_pos        = p[ADDR_W-1:0];
        o.play_position = play_pos;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            play_pos      = '0;
            skip_pos      = SKIP_RESET;
            frame_count   = FRAME_COUNT_RESET;
            skip_interval = '0;
            step_forward  = 1'b0;
            volume_gain   = GAIN_RESET;
            player_out_q.delete();
            o_pending     = 0;
            o_fail_count  = 0;
        end else begin
            // response first, so a new request never hides a spurious strobe
            if (i_done) begin
                if (player_out_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_SHOWN)
                        $display("%0t: response with none pending: left %0d right %0d position %0d",
                                 $time, i_rsp.left_out, i_rsp.right_out, i_rsp.play_position);
                end else begin
                    want = player_out_q.pop_front();
                    o_pending--;
                    if (i_rsp !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_SHOWN)
                            $display({"%0t: mismatch: expected left %0d right %0d position %0d,",
                                      " got left %0d right %0d position %0d"},
                                     $time, want.left_out, want.right_out, want.play_position,
                                     i_rsp.left_out, i_rsp.right_out, i_rsp.play_position);
                    end
                end
            end
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRAME_COUNT:   frame_count   = i_cfg_data[FRAME_COUNT_W-1:0];
                    CFG_SKIP_INTERVAL: skip_interval = i_cfg_data[SKIP_W-1:0];
                    CFG_STEP_FORWARD:  step_forward  = i_cfg_data[0];
                    CFG_VOLUME_GAIN:   volume_gain   = i_cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            // accepted request
            if (i_start && !i_busy) begin
                step_player(i_req, want);
                player_out_q.push_back(want);
                o_pending++;
            end
        end
    end

endmodule

@@ sim/looped_sample_player_with_skip_pitch_tb.sv @@
`timescale 1ns / 1ps

module looped_sample_player_with_skip_pitch_tb;
    import lsp_pkg::*;

    localparam int FRAMES      = DEF_MAX_FRAMES;
    localparam int SPAN        = DEF_SEARCH_SPAN;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 500;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_start     = 1'b0;
    t_req                   i_req       = '0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_busy;
    logic                   o_done;
    t_rsp                   o_rsp;
    logic                   o_cfg_ready;
    int                     fail_count;
    int                     pending;

    // Stimulus bookkeeping: which frames hold data and how far play can reach
    bit loaded [0:FRAMES-1];
    int prefix     = 0;
    int pos_bound  = 0;
    int loop_len   = FRAMES;
    int idle_pct   = 16;
    int random_cnt = 0;
    int stall_cycles = 0;

    looped_sample_player_with_skip_pitch DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    lsp_player_checker #(.SPAN(SPAN)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: too long without any handshake or response
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_req req_of(input logic [1:0] mode, input int addr, input int left,
                                    input int right, input int pv, input bit rising);
        t_req r;
        r.mode               = mode;
        r.load_address       = addr[ADDR_W-1:0];
        r.load_left          = left[SAMPLE_W-1:0];
        r.load_right         = right[SAMPLE_W-1:0];
        r.partner_last_value = pv[SAMPLE_W-1:0];
        r.partner_rising     = rising;
        return r;
    endfunction

    // Highest frame index a play or align may read, from the position bound
    function automatic int frames_needed(input logic [1:0] mode);
        int reach;
        if (mode == MODE_PLAY) reach = pos_bound + 1;
        else if (mode == MODE_ALIGN) reach = pos_bound + SPAN;
        else return -1;
        if (reach > loop_len - 1) reach = loop_len - 1;
        return (reach > pos_bound) ? reach : pos_bound;
    endfunction

    // Random request; a play or align that could read an empty frame
    // becomes a load that fills the loop instead
    function automatic t_req random_request();
        t_req r;
        int   pick;
        int   need;
        int   addr;
        r.load_address       = ADDR_W'($urandom);
        r.load_left          = SAMPLE_W'($urandom);
        r.load_right         = SAMPLE_W'($urandom);
        r.partner_last_value = SAMPLE_W'($urandom);
        r.partner_rising     = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30) r.mode = MODE_LOAD;
        else if (pick < 75) r.mode = MODE_PLAY;
        else if (pick < 90) r.mode = MODE_ALIGN;
        else r.mode = MODE_NOP;
        if (r.mode == MODE_ALIGN) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) r.partner_last_value = 16'sh8000;
            else if (pick == 1) r.partner_last_value = 16'sh7fff;
        end
        need = frames_needed(r.mode);
        if (prefix <= need || (r.mode == MODE_PLAY && !loaded[loop_len-1])) begin
            r.mode         = MODE_LOAD;
            r.load_address = ADDR_W'((prefix <= need) ? prefix : loop_len - 1);
        end else if (r.mode == MODE_LOAD) begin
            pick = $urandom_range(0, 3);
            if (pick == 1) r.load_address = ADDR_W'($urandom_range(0, loop_len - 1));
            else if (pick >= 2 && prefix < FRAMES) r.load_address = ADDR_W'(prefix);
        end
        // ramps give long monotone runs where no crossing is found
        if (r.mode == MODE_LOAD && $urandom_range(0, 1)) begin
            addr         = r.load_address;
            r.load_left  = SAMPLE_W'(addr * 97 - 3000);
            r.load_right = ~r.load_left;
        end
        return r;
    endfunction

    // Sends one request and waits until it is taken
    task automatic issue(input t_req r);
        case (r.mode)
            MODE_LOAD: begin
                loaded[r.load_address] = 1'b1;
                while (prefix < FRAMES && loaded[prefix]) prefix++;
            end
            MODE_PLAY: begin
                pos_bound = (pos_bound + 2 < loop_len - 1) ? pos_bound + 2 : loop_len - 1;
            end
            MODE_ALIGN: begin
                pos_bound = frames_needed(MODE_ALIGN);
            end
            default: begin
            end
        endcase
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Holds requests back until every response is in
    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // One setting of all registers, then random requests
    task automatic run_phase(input int fc, input int interval, input bit fwd,
                             input int gain, input int count);
        logic [FRAME_COUNT_W-1:0] fc_bits;
        int k;
        fc_bits = fc[FRAME_COUNT_W-1:0];
        wait_drained();
        write_reg(CFG_FRAME_COUNT, {7'($urandom), fc_bits});
        write_reg(CFG_SKIP_INTERVAL, interval[SKIP_W-1:0]);
        write_reg(CFG_STEP_FORWARD, {23'($urandom), fwd});
        write_reg(CFG_VOLUME_GAIN, {8'($urandom), gain[GAIN_W-1:0]});
        i_cfg_valid <= 1'b0;
        if (fc_bits == 0) loop_len = 1;
        else if (fc_bits > FRAMES) loop_len = FRAMES;
        else loop_len = fc_bits;
        for (k = 0; k < count; k++) begin
            if (random_cnt < 510) idle_pct = 16;
            else if (random_cnt < 1020) idle_pct = 57;
            else idle_pct = 0;
            if ($urandom_range(0, 99) == 0) wait_drained();
            issue(random_request());
            random_cnt++;
        end
    endtask

    // Extreme samples, every mode, crossings in both directions and
    // partner values that can never be crossed
    task automatic run_directed();
        int corner_left  [8] = '{32767, -32768, 0, -1, 100, 32767, -32768, 1};
        int corner_right [8] = '{-32768, 32767, 0, 1, -100, 32767, -32768, -1};
        int k;
        for (k = 0; k < 8; k++)
            issue(req_of(MODE_LOAD, k, corner_left[k], corner_right[k], 0, 1'b0));
        issue(req_of(MODE_LOAD, FRAMES - 1, -32768, 32767, 0, 1'b0));
        issue(req_of(MODE_NOP, 'hffff, -1, -1, -1, 1'b1));
        for (k = 0; k < 4; k++) issue(req_of(MODE_PLAY, 0, 0, 0, 0, 1'b0));
        issue(req_of(MODE_ALIGN, 0, 0, 0, 0, 1'b1));
        issue(req_of(MODE_ALIGN, 0, 0, 0, 0, 1'b0));
        issue(req_of(MODE_ALIGN, 0, 0, 0, -32768, 1'b1));
        issue(req_of(MODE_ALIGN, 0, 0, 0, 32767, 1'b0));
        for (k = 0; k < 3; k++) issue(req_of(MODE_PLAY, 0, 0, 0, 0, 1'b0));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(8, 0, 1'b0, GAIN_RESET, 0);
        run_directed();
        run_phase(16, 'h000380, 1'b1, 4096, 170);
        // full-scale gain saturates, repeat steps wrap back from frame 0
        run_phase(16, 'h000200, 1'b0, 65535, 170);
        // one-frame loop, zero gain, skip position overflow
        run_phase(0, 'hffffff, 1'b0, 0, 100);
        run_phase(64, 'h000a40, 1'b1, 12288, 180);
        // shrinking the loop leaves a stale position
        run_phase(5, 'h000180, 1'b0, 4096, 150);
        run_phase('h1ffff, 'h00c000, 1'b1, $urandom_range(0, 65535), 200);
        run_phase(300, $urandom_range(256, 16384), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 65535), 220);
        run_phase(2, 'h000100, 1'b0, 2048, 130);
        run_phase($urandom_range(2, 40), $urandom_range(0, 4096), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 65535), 180);
        run_phase(FRAMES, 0, 1'b0, GAIN_RESET, 30);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
